// ----- design/composite_key_command_sorter_macros.svh -----
// Assertion macros shared by the sorter RTL.
// No dependencies; the top level takes this file by include.
`ifndef COMPOSITE_KEY_COMMAND_SORTER_MACROS_SVH
`define COMPOSITE_KEY_COMMAND_SORTER_MACROS_SVH
`ifndef SYNTHESIS
// Check that cond implies prop in the same cycle.
`define CKS_ASSERT_IMP(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("sorter assertion failed");
// Check that cond implies prop in the next cycle.
`define CKS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("sorter assertion failed");
`else
`define CKS_ASSERT_IMP(label, clk, rst_n, cond, prop)
`define CKS_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

// ----- design/cksort_pkg.sv -----
// Types, constants and the key compare for the command sorter.
// No dependencies; used by the cell and the top level.
package cksort_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int KEY_W     = 64;
	localparam int IDX_W     = 6;

	// Request payload of the input channel.
	typedef struct packed {
		logic [7:0]        stencil_ref;
		logic signed [7:0] draw_layer;
		logic [31:0]       distance;
		logic [13:0]       draw_id;
		logic [1:0]        cam_sel;
		logic              last_item;
	} cksort_in_t;

	// Request payload of the output channel.
	typedef struct packed {
		logic [5:0] original_index;
		logic       last_result;
		logic       overflow;
	} cksort_out_t;

	// One stored command: packed key and arrival position.
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [IDX_W-1:0] origin;
	} cksort_ent_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SORT,
		ST_EMIT
	} cksort_state_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_LOAD,
		OP_SORT,
		OP_EMIT
	} cksort_op_t;

	// Per-cell control from the sequencer.
	typedef struct packed {
		cksort_op_t op;
		logic       swap_l;
		logic       swap_r;
	} cksort_ctl_t;

	// Map a key to a word whose unsigned order is the wanted order.
	function automatic logic [KEY_W-1:0] order_word(logic [KEY_W-1:0] key, logic transparent);
		logic [KEY_W-1:0] w;
		w = key ^ {8'h00, 8'h80, 48'h0};
		if (transparent) begin
			w = w ^ {16'h0000, 32'hFFFF_FFFF, 16'h0000};
		end else begin
			w = w & {8'h00, 56'hFF_FFFF_FFFF_FFFF};
		end
		return w;
	endfunction

	// True when a sorts after b; arrival position breaks full ties.
	function automatic logic ent_gt(cksort_ent_t a, cksort_ent_t b, logic transparent);
		logic [KEY_W+IDX_W-1:0] wa;
		logic [KEY_W+IDX_W-1:0] wb;
		wa = {order_word(a.key, transparent), a.origin};
		wb = {order_word(b.key, transparent), b.origin};
		return wa > wb;
	endfunction

endpackage

// ----- design/cksort_cell.sv -----
// One sorter cell: holds a command, shifts or swaps with its neighbors.
// Depends on cksort_pkg.
module cksort_cell (
	input  logic                  clk,
	input  cksort_pkg::cksort_ctl_t ctl,
	input  logic                  mode,
	input  cksort_pkg::cksort_ent_t left_ent,
	input  cksort_pkg::cksort_ent_t right_ent,
	output cksort_pkg::cksort_ent_t ent,
	output logic                  gt_right
);
	import cksort_pkg::*;

	cksort_ent_t ent_q;

	// Shift in on load, exchange on sort, shift out on emit
	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_LOAD: ent_q <= left_ent;
			OP_SORT: begin
				if (ctl.swap_l) begin
					ent_q <= left_ent;
				end else if (ctl.swap_r) begin
					ent_q <= right_ent;
				end
			end
			OP_EMIT: ent_q <= right_ent;
			default: ent_q <= ent_q;
		endcase
	end

	// Compare against the right neighbor
	assign gt_right = ent_gt(ent_q, right_ent, mode);
	assign ent      = ent_q;

endmodule

// ----- design/composite_key_command_sorter.sv -----
// Top level of the draw-command sorter: sequencer, cell row, output register.
// Depends on cksort_pkg, cksort_cell and composite_key_command_sorter_macros.svh.
//
//  channel  signals                      direction  payload
//  in       in_valid / in_ready          to block   cksort_in_t (one command key)
//  out      out_valid / out_ready        from block cksort_out_t (one sorted index)
//  cfg      cfg_we / cfg_wdata           to block   transparent_mode bit
//
// While loading, commands enter the cell row at cell 0 and shift along it.
// The item marked last starts the odd-even exchange sort of the row,
// then one index per cycle leaves cell 0 while the output register is free.
// Input is refused during sorting and emission; output stalls hold the row.
// Reset clears the sequencer, counts and mode; the cell contents need no reset.
`include "composite_key_command_sorter_macros.svh"
module composite_key_command_sorter #(
	parameter int DEPTH = cksort_pkg::DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic                   cfg_wdata,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  cksort_pkg::cksort_in_t in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output cksort_pkg::cksort_out_t out_data
);
	import cksort_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int PH_W  = $clog2(DEPTH);

	cksort_state_t st_q, st_d;
	logic [CNT_W-1:0] count_q;
	logic [PH_W-1:0]  phase_q;
	logic             dropped_q;
	logic             mode_q;
	logic             out_valid_q;
	cksort_out_t      out_q;

	logic        in_fire;
	logic        emit_fire;
	logic        emit_last;
	logic        full;
	cksort_op_t  op;
	cksort_ent_t new_ent;
	cksort_ent_t ents [DEPTH];
	logic [DEPTH-1:0] gt;
	logic [DEPTH-1:0] swap;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign emit_last = emit_fire && (count_q == CNT_W'(1));

	// Build the entry for an arriving command
	assign new_ent.key    = {in_data.stencil_ref, in_data.draw_layer, in_data.distance,
	                         in_data.draw_id, in_data.cam_sel};
	assign new_ent.origin = IDX_W'(count_q);

	// Next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_LOAD: if (in_fire && in_data.last_item) st_d = ST_SORT;
			ST_SORT: if (phase_q == PH_W'(DEPTH - 1)) st_d = ST_EMIT;
			ST_EMIT: if (emit_fire && count_q == CNT_W'(1)) st_d = ST_LOAD;
			default: st_d = ST_LOAD;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_ready  = (st_q == ST_LOAD);
		in_fire   = in_valid && in_ready;
		emit_fire = (st_q == ST_EMIT) && (!out_valid_q || out_ready);
		op        = OP_HOLD;
		unique case (st_q)
			ST_LOAD: if (in_fire && !full) op = OP_LOAD;
			ST_SORT: op = OP_SORT;
			ST_EMIT: if (emit_fire) op = OP_EMIT;
			default: op = OP_HOLD;
		endcase
	end

	// Advance state, counts and mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_LOAD;
			count_q   <= '0;
			phase_q   <= '0;
			dropped_q <= 1'b0;
			mode_q    <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (st_q == ST_SORT) begin
				phase_q <= phase_q + PH_W'(1);
			end else begin
				phase_q <= '0;
			end
			if (in_fire) begin
				if (full) begin
					dropped_q <= 1'b1;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
			end else if (emit_fire) begin
				count_q   <= count_q - CNT_W'(1);
				dropped_q <= 1'b0;
			end
		end
	end

	// Output register: load on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_q.original_index <= ents[0].origin;
			out_q.last_result    <= (count_q == CNT_W'(1));
			out_q.overflow       <= dropped_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Cell row with exchange decisions per neighbor pair
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cksort_ctl_t ctl;

		assign swap[i] = (phase_q[0] == 1'(i % 2)) && (count_q > CNT_W'(i + 1)) && gt[i];

		assign ctl.op     = op;
		assign ctl.swap_l = (i == 0) ? 1'b0 : swap[(i == 0) ? 0 : i - 1];
		assign ctl.swap_r = swap[i];

		cksort_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.mode      (mode_q),
			.left_ent  ((i == 0) ? new_ent : ents[(i == 0) ? 0 : i - 1]),
			.right_ent ((i == DEPTH - 1) ? cksort_ent_t'('0)
			                             : ents[(i == DEPTH - 1) ? i : i + 1]),
			.ent       (ents[i]),
			.gt_right  (gt[i])
		);
	end

	// Emission never runs on an empty row
	`CKS_ASSERT_IMP(a_emit_nonempty, clk, arst_n, st_q == ST_EMIT, count_q != '0)
	// The last command always starts a sort
	`CKS_ASSERT_NEXT(a_last_sorts, clk, arst_n, in_fire && in_data.last_item, st_q == ST_SORT)
	// The final index returns the block to loading with an empty row
	`CKS_ASSERT_NEXT(a_end_clears, clk, arst_n, emit_last, st_q == ST_LOAD && count_q == '0)

endmodule

// ----- sim/composite_key_command_sorter_tb.sv -----
// Testbench for composite_key_command_sorter: loads command sets, predicts sorted order.
// Depends on cksort_pkg and the composite_key_command_sorter RTL; needs nothing else.
module composite_key_command_sorter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cksort_pkg::*;

	localparam int DEPTH      = DEPTH_DEF;
	localparam int RAND_ITEMS = 30;
	localparam int SETTLE     = 2 * DEPTH + 8;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	cksort_in_t  in_data   = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	cksort_out_t out_data;

	// Predictor state: commands of the open set, drop flag, current mode.
	cksort_in_t  open_set[$];
	logic        set_dropped   = 1'b0;
	logic        transparent_q = 1'b0;
	cksort_out_t sorted_q[$];

	int          mismatch_count = 0;
	bit          idle_on        = 1'b1;
	int          stall_left     = 0;
	cksort_out_t want;

	composite_key_command_sorter #(.DEPTH(DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #5 clk = ~clk;

	// Build a sort word whose unsigned order is the draw order in the given mode.
	function automatic logic [63:0] draw_rank(cksort_in_t c, logic transp);
		logic [7:0] layer_biased;
		layer_biased = {~c.draw_layer[7], c.draw_layer[6:0]};
		if (transp)
			return {c.stencil_ref, layer_biased, ~c.distance, c.draw_id, c.cam_sel};
		return {8'h00, layer_biased, c.distance, c.draw_id, c.cam_sel};
	endfunction

	// Store an accepted command; on the last one, queue the stable sorted indices.
	function automatic void book_command(cksort_in_t c);
		logic [63:0] words[$];
		int          order[$];
		logic [63:0] w;
		int          p;
		cksort_out_t r;
		if (open_set.size() < DEPTH)
			open_set.insert(open_set.size(), c);
		else
			set_dropped = 1'b1;
		if (!c.last_item)
			return;
		for (int i = 0; i < open_set.size(); i++) begin
			w = draw_rank(open_set[i], transparent_q);
			p = words.size();
			while (p > 0 && w < words[p-1])
				p--;
			words.insert(p, w);
			order.insert(p, i);
		end
		for (int k = 0; k < order.size(); k++) begin
			r.original_index = 6'(order[k]);
			r.last_result    = (k == order.size() - 1);
			r.overflow       = (k == 0) ? set_dropped : 1'b0;
			sorted_q.insert(sorted_q.size(), r);
		end
		open_set.delete();
		set_dropped = 1'b0;
	endfunction

	function automatic cksort_in_t make_cmd(logic [7:0] stencil, logic signed [7:0] layer,
			logic [31:0] dist_val, logic [13:0] id, logic [1:0] cam, logic last);
		cksort_in_t c;
		c.stencil_ref = stencil;
		c.draw_layer  = layer;
		c.distance    = dist_val;
		c.draw_id     = id;
		c.cam_sel     = cam;
		c.last_item   = last;
		return c;
	endfunction

	// Random command: half from narrow pools so that key ties are common.
	function automatic cksort_in_t rand_cmd(logic last);
		cksort_in_t c;
		if ($urandom_range(0, 1) == 0) begin
			c.stencil_ref = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			c.draw_layer  = 8'($urandom_range(0, 2)) - 8'd1;
			c.distance    = 32'($urandom_range(0, 2)) << 16;
			c.draw_id     = 14'($urandom_range(0, 1));
			c.cam_sel     = 2'($urandom_range(0, 3));
		end else begin
			c.stencil_ref = 8'($urandom);
			c.draw_layer  = 8'($urandom);
			c.distance    = $urandom;
			c.draw_id     = 14'($urandom);
			c.cam_sel     = 2'($urandom);
		end
		c.last_item = last;
		return c;
	endfunction

	// Send one request on the input channel, with an occasional idle burst first.
	task automatic send_command(input cksort_in_t cmd);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= cmd;
		do @(posedge clk); while (!in_ready);
		book_command(cmd);
	endtask

	// Drop valid, wait for all queued results, then let the block settle.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sorted_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_mode(input logic transp);
		cfg_we    <= 1'b1;
		cfg_wdata <= transp;
		@(posedge clk);
		cfg_we        <= 1'b0;
		transparent_q = transp;
	endtask

	task automatic test_single_command();
		send_command(make_cmd(8'h12, 8'sd3, 32'h0002_8000, 14'd9, 2'd1, 1'b1));
	endtask

	// Opaque: layer extremes, distance extremes, stencil ignored, a full tie.
	task automatic test_opaque_order();
		wait_drained();
		set_mode(1'b0);
		send_command(make_cmd(8'hFF, 8'sd127, 32'h0, 14'h0, 2'd0, 1'b0));
		send_command(make_cmd(8'h00, -8'sd128, 32'hFFFF_FFFF, 14'h3FFF, 2'd3, 1'b0));
		send_command(make_cmd(8'h00, -8'sd128, 32'h0, 14'h3FFF, 2'd3, 1'b0));
		send_command(make_cmd(8'h55, 8'sd0, 32'h0001_0000, 14'd5, 2'd2, 1'b0));
		send_command(make_cmd(8'hAA, 8'sd0, 32'h0001_0000, 14'd5, 2'd1, 1'b0));
		send_command(make_cmd(8'h01, -8'sd1, 32'h8000_0000, 14'd100, 2'd0, 1'b0));
		send_command(make_cmd(8'h02, 8'sd0, 32'h0001_0000, 14'd5, 2'd1, 1'b0));
		send_command(make_cmd(8'h00, 8'sd127, 32'hFFFF_FFFF, 14'h0, 2'd0, 1'b1));
	endtask

	// Transparent: stencil first, distance descending, identical keys stay in order.
	task automatic test_transparent_order();
		wait_drained();
		set_mode(1'b1);
		send_command(make_cmd(8'hFF, -8'sd128, 32'h0, 14'h0, 2'd0, 1'b0));
		send_command(make_cmd(8'h00, 8'sd127, 32'h0, 14'h3FFF, 2'd3, 1'b0));
		send_command(make_cmd(8'h00, 8'sd127, 32'hFFFF_FFFF, 14'h3FFF, 2'd3, 1'b0));
		send_command(make_cmd(8'h80, 8'sd0, 32'd10, 14'd7, 2'd1, 1'b0));
		send_command(make_cmd(8'h80, 8'sd0, 32'd10, 14'd7, 2'd1, 1'b0));
		send_command(make_cmd(8'h80, 8'sd0, 32'd20, 14'd7, 2'd1, 1'b0));
		send_command(make_cmd(8'h00, -8'sd1, 32'd5, 14'd0, 2'd2, 1'b1));
	endtask

	// Switch the mode while a set is half loaded; the last request decides.
	task automatic test_mode_switch_midset();
		wait_drained();
		set_mode(1'b0);
		send_command(make_cmd(8'h01, 8'sd0, 32'd100, 14'd1, 2'd0, 1'b0));
		send_command(make_cmd(8'h00, 8'sd0, 32'd200, 14'd1, 2'd0, 1'b0));
		send_command(make_cmd(8'h01, 8'sd0, 32'd300, 14'd1, 2'd0, 1'b0));
		send_command(make_cmd(8'h00, 8'sd0, 32'd400, 14'd1, 2'd0, 1'b0));
		wait_drained();
		set_mode(1'b1);
		send_command(make_cmd(8'h00, 8'sd0, 32'd50, 14'd1, 2'd0, 1'b1));
	endtask

	// Fill the store exactly, then overfill it by two requests, the last one among those dropped.
	task automatic test_full_store();
		for (int k = 0; k < DEPTH; k++)
			send_command(rand_cmd(k == DEPTH - 1));
		for (int k = 0; k < DEPTH + 2; k++)
			send_command(rand_cmd(k == DEPTH + 1));
	endtask

	// Random small sets; mode changes between some of them.
	task automatic test_random_sets();
		int sent;
		int set_len;
		sent = 0;
		while (sent < RAND_ITEMS) begin
			if ($urandom_range(0, 2) == 0) begin
				wait_drained();
				set_mode(1'($urandom_range(0, 1)));
			end
			set_len = $urandom_range(1, 12);
			for (int k = 0; k < set_len; k++)
				send_command(rand_cmd(k == set_len - 1));
			sent += set_len;
			if (sent >= RAND_ITEMS * 3 / 4)
				idle_on = 1'b0;
		end
	endtask

	// Stall the output channel in short random bursts.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 2);
			out_ready  <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Compare each accepted result with the oldest expected index.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (sorted_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: idx %0d last %0b ovf %0b",
						out_data.original_index, out_data.last_result, out_data.overflow);
			end else begin
				want = sorted_q.pop_front();
				if (out_data.original_index !== want.original_index ||
						out_data.last_result !== want.last_result ||
						out_data.overflow !== want.overflow) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: want %0d/%0b/%0b got %0d/%0b/%0b",
							want.original_index, want.last_result, want.overflow,
							out_data.original_index, out_data.last_result,
							out_data.overflow);
				end
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_command();
		test_opaque_order();
		test_transparent_order();
		test_mode_switch_midset();
		test_full_store();
		test_random_sets();
		wait_drained();
		if (sorted_q.size() != 0)
			mismatch_count++;
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Hard stop well past the slowest legal run.
	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+design
design/cksort_pkg.sv
design/cksort_cell.sv
design/composite_key_command_sorter.sv
sim/composite_key_command_sorter_tb.sv
